### design/lbdr_pkg.sv
`default_nettype none
package lbdr_pkg;

	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned BTN_W    = 7;
	localparam int unsigned CODE_W   = 3;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned MS_W     = 16;
	localparam int unsigned WIN_NUM  = 6;
	localparam int unsigned CFG_W    = 32;
	localparam int unsigned IDX_W    = 3;

	// button bit layout
	localparam logic [BTN_W-1:0] BIT_NONE    = 7'h00;
	localparam logic [BTN_W-1:0] BIT_LEFT    = 7'h01;
	localparam logic [BTN_W-1:0] BIT_RIGHT   = 7'h02;
	localparam logic [BTN_W-1:0] BIT_UP      = 7'h04;
	localparam logic [BTN_W-1:0] BIT_DOWN    = 7'h08;
	localparam logic [BTN_W-1:0] BIT_CONFIRM = 7'h10;
	localparam logic [BTN_W-1:0] BIT_BACK    = 7'h20;
	localparam logic [BTN_W-1:0] BIT_POWER   = 7'h40;

	// register indexes
	localparam logic [IDX_W-1:0] REG_RIGHT    = 3'd0;
	localparam logic [IDX_W-1:0] REG_LEFT     = 3'd1;
	localparam logic [IDX_W-1:0] REG_CONFIRM  = 3'd2;
	localparam logic [IDX_W-1:0] REG_BACK     = 3'd3;
	localparam logic [IDX_W-1:0] REG_DOWN     = 3'd4;
	localparam logic [IDX_W-1:0] REG_UP       = 3'd5;
	localparam logic [IDX_W-1:0] REG_DEBOUNCE = 3'd6;
	localparam logic [IDX_W-1:0] REG_REPEAT   = 3'd7;

	localparam logic [MS_W-1:0]   DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_W-1:0]  REPEAT_RST   = {16'd500, 16'd150};

	typedef struct packed {
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
	} win_t;

	localparam win_t WIN_RST = '{lo: 12'hFFF, hi: 12'h000};

	typedef struct packed {
		logic [SAMPLE_W-1:0] ladder_a;
		logic [SAMPLE_W-1:0] ladder_b;
		logic                power_level;
		logic [TIME_W-1:0]   now_ms;
	} in_t;

	typedef struct packed {
		logic [BTN_W-1:0]  held_mask;
		logic [BTN_W-1:0]  pressed_mask;
		logic [CODE_W-1:0] first_pressed;
	} out_t;

	typedef struct packed {
		logic [MS_W-1:0] debounce;
		logic [MS_W-1:0] delay;
		logic [MS_W-1:0] rate;
	} timing_t;

	// lowest set bit as a 1-based code, 0 when empty
	function automatic logic [CODE_W-1:0] first_code(input logic [BTN_W-1:0] mask);
		logic [CODE_W-1:0] code;
		code = '0;
		for (int i = BTN_W - 1; i >= 0; i--) begin
			if (mask[i]) begin
				code = CODE_W'(i + 1);
			end
		end
		return code;
	endfunction

endpackage
`default_nettype wire

### design/lbdr_decode.sv
`default_nettype none
module lbdr_decode (
	input  wire lbdr_pkg::win_t [lbdr_pkg::WIN_NUM-1:0] windows,
	input  wire lbdr_pkg::in_t                          item,
	output logic [lbdr_pkg::BTN_W-1:0]                  code
);
	import lbdr_pkg::*;

	logic [WIN_NUM-1:0] hit;

	always_comb begin
		for (int i = 0; i < int'(WIN_NUM); i++) begin
			if (i < int'(REG_DOWN)) begin
				hit[i] = (item.ladder_a >= windows[i].lo) && (item.ladder_a <= windows[i].hi);
			end else begin
				hit[i] = (item.ladder_b >= windows[i].lo) && (item.ladder_b <= windows[i].hi);
			end
		end
	end

	// first matching window wins
	always_comb begin
		if (hit[REG_RIGHT]) begin
			code = BIT_RIGHT;
		end else if (hit[REG_LEFT]) begin
			code = BIT_LEFT;
		end else if (hit[REG_CONFIRM]) begin
			code = BIT_CONFIRM;
		end else if (hit[REG_BACK]) begin
			code = BIT_BACK;
		end else if (hit[REG_DOWN]) begin
			code = BIT_DOWN;
		end else if (hit[REG_UP]) begin
			code = BIT_UP;
		end else if (!item.power_level) begin
			code = BIT_POWER;
		end else begin
			code = BIT_NONE;
		end
	end

endmodule
`default_nettype wire

### design/lbdr_tracker.sv
`default_nettype none
module lbdr_tracker (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              step,
	input  wire [lbdr_pkg::BTN_W-1:0]        code,
	input  wire [lbdr_pkg::TIME_W-1:0]       now_ms,
	input  wire lbdr_pkg::timing_t           timing,
	output lbdr_pkg::out_t                   result
);
	import lbdr_pkg::*;

	logic [BTN_W-1:0]  stable_q;
	logic [TIME_W-1:0] last_change_q;
	logic [TIME_W-1:0] last_repeat_q;
	logic              in_repeat_q;

	logic [TIME_W-1:0] since_change;
	logic [TIME_W-1:0] since_repeat;
	logic [MS_W-1:0]   interval;
	logic              take_change;
	logic              take_repeat;
	logic [BTN_W-1:0]  held_next;
	logic [BTN_W-1:0]  pressed;

	always_comb begin
		since_change = now_ms - last_change_q;
		since_repeat = now_ms - last_repeat_q;
		interval     = in_repeat_q ? timing.rate : timing.delay;
		take_change  = (code != stable_q) &&
			(since_change >= {{(TIME_W-MS_W){1'b0}}, timing.debounce});
		take_repeat  = (code == stable_q) && (stable_q != BIT_NONE) &&
			(since_repeat >= {{(TIME_W-MS_W){1'b0}}, interval});
		held_next    = take_change ? code : stable_q;
		if (take_change) begin
			pressed = code & ~stable_q;
		end else if (take_repeat) begin
			pressed = stable_q;
		end else begin
			pressed = BIT_NONE;
		end
		result.held_mask     = held_next;
		result.pressed_mask  = pressed;
		result.first_pressed = first_code(pressed);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q      <= '0;
			last_change_q <= '0;
			last_repeat_q <= '0;
			in_repeat_q   <= 1'b0;
		end else if (step) begin
			if (take_change) begin
				stable_q      <= code;
				last_change_q <= now_ms;
				last_repeat_q <= now_ms;
				in_repeat_q   <= 1'b0;
			end else if (take_repeat) begin
				last_repeat_q <= now_ms;
				in_repeat_q   <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### design/ladder_button_debounce_repeat.sv
`default_nettype none
// A poll is captured in the input register; its result is then registered in the result register.
// Throughput: one poll per cycle while the result register is empty or its item is taken in
// the same cycle; both registers then advance together, and an empty input register loads too.
// Reset (arst_n low, asynchronous): both valid flags clear, button state and timestamps
// go to zero, windows to min 4095 / max 0, debounce to 50 ms, delay 500 ms, rate 150 ms.
module ladder_button_debounce_repeat (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire lbdr_pkg::in_t           in_data,
	output logic                         out_valid,
	input  wire                          out_ready,
	output lbdr_pkg::out_t               out_data,
	input  wire                          cfg_we,
	input  wire [lbdr_pkg::IDX_W-1:0]    cfg_index,
	input  wire [lbdr_pkg::CFG_W-1:0]    cfg_data
);
	import lbdr_pkg::*;

	win_t [WIN_NUM-1:0] windows_q;
	logic [MS_W-1:0]    debounce_q;
	logic [CFG_W-1:0]   repeat_q;

	in_t              item_s1;
	logic             valid_s1;
	logic             advance;
	logic [BTN_W-1:0] code;
	timing_t          timing;
	out_t             result;
	out_t             out_q;
	logic             out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(WIN_NUM); i++) begin
				windows_q[i] <= WIN_RST;
			end
			debounce_q <= DEBOUNCE_RST;
			repeat_q   <= REPEAT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data[MS_W-1:0];
				REG_REPEAT:   repeat_q   <= cfg_data;
				default: begin
					for (int i = 0; i < int'(WIN_NUM); i++) begin
						if (cfg_index == IDX_W'(i)) begin
							windows_q[i] <= cfg_data[2*SAMPLE_W-1:0];
						end
					end
				end
			endcase
		end
	end

	assign timing.debounce = debounce_q;
	assign timing.delay    = repeat_q[CFG_W-1:MS_W];
	assign timing.rate     = repeat_q[MS_W-1:0];

	// stage 1 moves into the result register when that register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	lbdr_decode u_decode (
		.windows (windows_q),
		.item    (item_s1),
		.code    (code)
	);

	lbdr_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.code   (code),
		.now_ms (item_s1.now_ms),
		.timing (timing),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

### tb/button_poll_checker.sv
`default_nettype none
module button_poll_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire                          in_ready,
	input  lbdr_pkg::in_t                in_data,
	input  wire                          out_valid,
	input  wire                          out_ready,
	input  lbdr_pkg::out_t               out_data,
	input  wire                          cfg_we,
	input  wire [lbdr_pkg::IDX_W-1:0]    cfg_index,
	input  wire [lbdr_pkg::CFG_W-1:0]    cfg_data,
	output int                           errors,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import lbdr_pkg::*;

	// window registers are listed in decode priority order
	localparam logic [BTN_W-1:0] WINDOW_BUTTON [WIN_NUM] = '{
		BIT_RIGHT, BIT_LEFT, BIT_CONFIRM, BIT_BACK, BIT_DOWN, BIT_UP
	};

	win_t              windows [WIN_NUM];
	logic [MS_W-1:0]   settle_ms;
	logic [MS_W-1:0]   first_delay;
	logic [MS_W-1:0]   repeat_rate;
	logic [BTN_W-1:0]  held;
	logic [TIME_W-1:0] change_ms;
	logic [TIME_W-1:0] repeat_ms;
	logic              repeating;
	out_t              expected_reports [$];
	out_t              want;
	int                fail_count = 0;

	function automatic logic [BTN_W-1:0] ladder_code(input in_t p);
		logic [SAMPLE_W-1:0] x;
		for (int i = 0; i < WIN_NUM; i++) begin
			x = (i < int'(REG_DOWN)) ? p.ladder_a : p.ladder_b;
			if (x >= windows[i].lo && x <= windows[i].hi) begin
				return WINDOW_BUTTON[i];
			end
		end
		return p.power_level ? BIT_NONE : BIT_POWER;
	endfunction

	function automatic logic [CODE_W-1:0] button_code(input logic [BTN_W-1:0] mask);
		for (int i = 0; i < BTN_W; i++) begin
			if (mask[i]) begin
				return CODE_W'(i + 1);
			end
		end
		return '0;
	endfunction

	// advances the debounce / repeat state by one poll
	function automatic out_t predict_poll(input in_t p);
		logic [BTN_W-1:0]  code;
		logic [BTN_W-1:0]  pressed;
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] interval;
		out_t              r;
		code = ladder_code(p);
		pressed = BIT_NONE;
		if (code != held) begin
			elapsed = p.now_ms - change_ms;
			if (elapsed >= TIME_W'(settle_ms)) begin
				pressed = code & ~held;
				held = code;
				change_ms = p.now_ms;
				repeat_ms = p.now_ms;
				repeating = 1'b0;
			end
		end else if (held != BIT_NONE) begin
			interval = repeating ? TIME_W'(repeat_rate) : TIME_W'(first_delay);
			elapsed = p.now_ms - repeat_ms;
			if (elapsed >= interval) begin
				pressed = held;
				repeat_ms = p.now_ms;
				repeating = 1'b1;
			end
		end
		r.held_mask = held;
		r.pressed_mask = pressed;
		r.first_pressed = button_code(pressed);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_NUM; i++) begin
				windows[i] = WIN_RST;
			end
			settle_ms = DEBOUNCE_RST;
			{first_delay, repeat_rate} = REPEAT_RST;
			held = BIT_NONE;
			change_ms = '0;
			repeat_ms = '0;
			repeating = 1'b0;
			expected_reports.delete();
			pending <= 0;
			errors <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DEBOUNCE: settle_ms = cfg_data[MS_W-1:0];
					REG_REPEAT:   {first_delay, repeat_rate} = cfg_data;
					default:      windows[cfg_index] = cfg_data[2*SAMPLE_W-1:0];
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					$error("unexpected result: held_mask %0h pressed_mask %0h first_pressed %0d",
						out_data.held_mask, out_data.pressed_mask, out_data.first_pressed);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					if (out_data.held_mask !== want.held_mask) begin
						$error("held_mask: expected %0h, got %0h",
							want.held_mask, out_data.held_mask);
						fail_count++;
					end
					if (out_data.pressed_mask !== want.pressed_mask) begin
						$error("pressed_mask: expected %0h, got %0h",
							want.pressed_mask, out_data.pressed_mask);
						fail_count++;
					end
					if (out_data.first_pressed !== want.first_pressed) begin
						$error("first_pressed: expected %0d, got %0d",
							want.first_pressed, out_data.first_pressed);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_reports.push_back(predict_poll(in_data));
			end
			pending <= expected_reports.size();
			errors <= fail_count;
		end
	end

endmodule
`default_nettype wire

### tb/tb.sv
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lbdr_pkg::*;

	localparam int TARGET_POWER = 6;
	localparam int TARGET_NONE  = 7;
	localparam int unsigned QUIET_LIMIT = 2000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = REG_RIGHT;
	logic [CFG_W-1:0] cfg_data = '0;
	int               errors;
	int               pending;

	int               idle_pct = 0;
	int               stall_pct = 0;
	int unsigned      step_max = 0;
	int unsigned      quiet_cycles = 0;
	logic [TIME_W-1:0] ms = '0;
	logic [2*SAMPLE_W-1:0] win_cfg [WIN_NUM];

	ladder_button_debounce_repeat uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	button_poll_checker poll_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// no transfer of any kind for too long means the block hung
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// valid stays high after a transfer; the next call or a drain decides
	task automatic send_poll(input in_t p);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic cfg_put(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_config(input logic [2*SAMPLE_W-1:0] w_right, w_left, w_confirm,
		w_back, w_down, w_up, input logic [MS_W-1:0] debounce, input logic [CFG_W-1:0] timing);
		win_cfg[REG_RIGHT]   = w_right;
		win_cfg[REG_LEFT]    = w_left;
		win_cfg[REG_CONFIRM] = w_confirm;
		win_cfg[REG_BACK]    = w_back;
		win_cfg[REG_DOWN]    = w_down;
		win_cfg[REG_UP]      = w_up;
		cfg_put(REG_RIGHT, CFG_W'(w_right));
		cfg_put(REG_LEFT, CFG_W'(w_left));
		cfg_put(REG_CONFIRM, CFG_W'(w_confirm));
		cfg_put(REG_BACK, CFG_W'(w_back));
		cfg_put(REG_DOWN, CFG_W'(w_down));
		cfg_put(REG_UP, CFG_W'(w_up));
		cfg_put(REG_DEBOUNCE, CFG_W'(debounce));
		cfg_put(REG_REPEAT, timing);
		cfg_we <= 1'b0;
	endtask

	task automatic poll(input logic [SAMPLE_W-1:0] a, b, input logic pwr,
		input logic [TIME_W-1:0] t);
		in_t p;
		p.ladder_a = a;
		p.ladder_b = b;
		p.power_level = pwr;
		p.now_ms = t;
		ms = t;
		send_poll(p);
	endtask

	function automatic bit hits(input logic [SAMPLE_W-1:0] x, input int first, last);
		for (int i = first; i <= last; i++) begin
			if (x >= win_cfg[i][2*SAMPLE_W-1:SAMPLE_W] && x <= win_cfg[i][SAMPLE_W-1:0]) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// a sample outside the given windows, if a few tries find one
	function automatic logic [SAMPLE_W-1:0] miss_sample(input int first, last);
		logic [SAMPLE_W-1:0] x;
		x = '0;
		for (int t = 0; t < 8; t++) begin
			x = SAMPLE_W'($urandom);
			if (!hits(x, first, last)) break;
		end
		return x;
	endfunction

	// inside the window, leaning on its edges; any sample when the window is empty
	function automatic logic [SAMPLE_W-1:0] aim(input logic [2*SAMPLE_W-1:0] w);
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		lo = w[2*SAMPLE_W-1:SAMPLE_W];
		hi = w[SAMPLE_W-1:0];
		if (lo > hi) return SAMPLE_W'($urandom);
		case ($urandom_range(0, 3))
			0:       return lo;
			1:       return hi;
			default: return SAMPLE_W'($urandom_range(hi, lo));
		endcase
	endfunction

	task automatic poll_button(input int target);
		in_t p;
		p.ladder_a = miss_sample(int'(REG_RIGHT), int'(REG_BACK));
		p.ladder_b = SAMPLE_W'($urandom);
		p.power_level = 1'($urandom);
		if (target <= int'(REG_BACK)) begin
			p.ladder_a = aim(win_cfg[target]);
		end else begin
			if (target <= int'(REG_UP)) begin
				p.ladder_b = aim(win_cfg[target]);
			end else begin
				p.ladder_b = miss_sample(int'(REG_DOWN), int'(REG_UP));
			end
			if (target == TARGET_POWER) begin
				p.power_level = 1'b0;
			end else if (target == TARGET_NONE) begin
				p.power_level = 1'b1;
			end
		end
		p.now_ms = ms;
		send_poll(p);
	endtask

	// holds of one button with the odd bounce and a little line noise
	task automatic run_phase(input int n);
		in_t p;
		int  target;
		int  hold;
		int  sent;
		sent = 0;
		while (sent < n) begin
			target = $urandom_range(0, TARGET_NONE);
			hold = $urandom_range(1, 30);
			for (int k = 0; k < hold && sent < n; k++) begin
				ms += $urandom_range(0, step_max);
				case ($urandom_range(0, 19))
					0: begin
						p.ladder_a = SAMPLE_W'($urandom);
						p.ladder_b = SAMPLE_W'($urandom);
						p.power_level = 1'($urandom);
						p.now_ms = $urandom;
						ms = p.now_ms;
						send_poll(p);
					end
					1:       poll_button($urandom_range(0, TARGET_NONE));
					default: poll_button(target);
				endcase
				sent++;
				if (sent % 100 == 0) wait_drained();
			end
		end
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < WIN_NUM; i++) begin
			win_cfg[i] = WIN_RST;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: no window matches, only power decodes
		poll(12'd0, 12'd0, 1'b1, 32'd0);
		poll(12'hFFF, 12'hFFF, 1'b0, 32'd10);
		poll(12'hFFF, 12'hFFF, 1'b0, 32'd50);
		poll(12'd0, 12'hFFF, 1'b0, 32'd549);
		poll(12'd0, 12'hFFF, 1'b0, 32'd550);
		poll(12'd0, 12'hFFF, 1'b0, 32'd699);
		poll(12'd0, 12'hFFF, 1'b0, 32'd700);
		poll(12'd0, 12'd0, 1'b1, 32'd720);
		poll(12'd0, 12'd0, 1'b0, 32'd750);
		wait_drained();

		// overlapping and empty windows, no debounce, repeat on every poll
		load_config(24'h000064, 24'h0320C8, 24'h12C0C8, 24'hFA0FFF, 24'h000FFF, 24'h00000A,
			16'd0, 32'h0000_0000);
		poll(12'd0, 12'd2048, 1'b1, 32'd1000);
		poll(12'd60, 12'd2048, 1'b1, 32'd1001);
		poll(12'd150, 12'd2048, 1'b1, 32'd1002);
		poll(12'd250, 12'd5, 1'b1, 32'd1003);
		poll(12'd4095, 12'd0, 1'b0, 32'd1004);
		poll(12'd4000, 12'd0, 1'b0, 32'd1004);
		poll(12'd3999, 12'd4095, 1'b0, 32'd1005);
		wait_drained();

		load_config(24'h000190, 24'h1F4320, 24'h384578, 24'h5DC7D0, 24'h0003E8, 24'h4B0898,
			16'd50, 32'h01F4_0096);
		idle_pct = 0;
		stall_pct = 0;
		step_max = 80;
		run_phase(246);

		load_config(24'h000190, 24'h1F4320, 24'h384578, 24'h5DC7D0, 24'h0003E8, 24'h4B0898,
			16'd20, 32'h0064_001E);
		idle_pct = 75;
		step_max = 40;
		run_phase(246);

		// single-value and full-range windows, longest times, timestamps wrapping
		load_config(24'h000000, 24'hFFFFFF, 24'h001FFF, 24'hFFF000, 24'h800FFF, 24'h000FFF,
			16'hFFFF, 32'hFFFF_FFFF);
		idle_pct = 0;
		stall_pct = 75;
		step_max = 40000;
		ms = 32'hFFFF_0000;
		run_phase(246);

		load_config(24'h0C8320, 24'h000258, 24'h1F4BB8, 24'h000FFF, 24'h000FFF, 24'h000064,
			16'd10, 32'h0005_0000);
		idle_pct = 17;
		stall_pct = 17;
		step_max = 12;
		run_phase(246);

		// delay shorter than rate
		load_config(24'h000190, 24'h1F4320, 24'h384578, 24'h5DC7D0, 24'h0003E8, 24'h4B0898,
			16'd100, 32'h0000_012C);
		idle_pct = 0;
		stall_pct = 0;
		step_max = 150;
		run_phase(246);

		repeat (4) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
